### hdl/gcbs_pkg.sv
// Shared types, codes and constants of the guided CDF bisection sampler.
package gcbs_pkg;

    // Field widths fixed by the transaction format.
    localparam int WORD_W       = 64;
    localparam int IDX_W        = 8;
    localparam int OUTCOMES     = 256;

    // Defaults of the top-level parameters.
    localparam int GUIDE_BITS_DEF = 8;
    localparam int TABLE_SETS_DEF = 4;

    // Number of halving steps the search may take.
    localparam int SEARCH_STEPS = 8;

    // Operation codes.
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_THR    = 2'd1;
    localparam logic [1:0] OP_GUIDE  = 2'd2;

    // Index whose threshold is checked first, and the answer at or above it.
    localparam logic [IDX_W-1:0] IDX_TOP_CHECK = 8'd254;
    localparam logic [IDX_W-1:0] IDX_TOP       = 8'd255;

    // Payload of one transaction as it moves down the search pipeline.
    // The word field holds the random word of a sample or the threshold of a write.
    typedef struct packed {
        logic [1:0]       op;
        logic [1:0]       set;
        logic [IDX_W-1:0] entry;
        logic [WORD_W-1:0] word;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic [IDX_W-1:0] mid;
        logic             act;
        logic             top;
    } stage_t;

    // Flat threshold store index of one entry of one set.
    function automatic logic [31:0] thr_index(input logic [1:0] set, input logic [IDX_W-1:0] idx);
        return {22'd0, set, idx};
    endfunction

endpackage

### hdl/gcbs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module gcbs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/gcbs_front.sv
// Front end: guide lookup, top threshold check and bound ordering.
module gcbs_front import gcbs_pkg::*; #(
    parameter int GUIDE_BITS = GUIDE_BITS_DEF,
    parameter int TABLE_SETS = TABLE_SETS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [1:0]        op,
    input  logic [1:0]        table_set,
    input  logic [IDX_W-1:0]  entry_index,
    input  logic [WORD_W-1:0] threshold_word,
    input  logic [IDX_W-1:0]  guide_low,
    input  logic [IDX_W-1:0]  guide_high,
    input  logic [WORD_W-1:0] random_word,
    output logic              valid_o,
    output stage_t            item_o
);

    localparam int THR_DEPTH   = TABLE_SETS * OUTCOMES;
    localparam int THR_AW      = $clog2(THR_DEPTH);
    localparam int GUIDE_DEPTH = TABLE_SETS << GUIDE_BITS;
    localparam int GUIDE_AW    = $clog2(GUIDE_DEPTH);

    // Reduces the 2-bit set field modulo the number of sets by repeated subtraction.
    function automatic logic [1:0] set_reduce(input logic [1:0] raw);
        logic [31:0] r;
        r = {30'd0, raw};
        for (int i = 0; i < 3; i++)
        begin
            if (r >= 32'(TABLE_SETS))
            begin
                r = r - 32'(TABLE_SETS);
            end
        end
        return r[1:0];
    endfunction

    logic                  in_fire;
    logic [1:0]            set_in;
    logic [GUIDE_BITS-1:0] guide_wslot;
    logic [GUIDE_BITS-1:0] guide_rslot;
    logic [31:0]           guide_widx;
    logic [31:0]           guide_ridx;
    logic [31:0]           thr_widx;
    logic [31:0]           thr_ridx;
    logic [15:0]           guide_q;
    logic [WORD_W-1:0]     top_q;

    logic   a_valid_reg;
    stage_t a_item_reg;
    stage_t a_item_next;
    logic   b_valid_reg;
    stage_t b_item_reg;
    stage_t b_item_next;

    // Store addresses for the incoming transaction.
    assign in_fire     = in_valid && adv;
    assign set_in      = set_reduce(table_set);
    assign guide_wslot = GUIDE_BITS'({{GUIDE_BITS{1'b0}}, entry_index});
    assign guide_rslot = random_word[WORD_W-1 -: GUIDE_BITS];
    assign guide_widx  = (32'(set_in) << GUIDE_BITS) | 32'(guide_wslot);
    assign guide_ridx  = (32'(set_in) << GUIDE_BITS) | 32'(guide_rslot);
    assign thr_widx    = thr_index(set_in, entry_index);
    assign thr_ridx    = thr_index(set_in, IDX_TOP_CHECK);

    // Guide store: low bound in the low byte, high bound in the high byte.
    gcbs_ram #(
        .WIDTH (16),
        .DEPTH (GUIDE_DEPTH)
    ) u_guide_ram (
        .clk   (clk),
        .we    (in_fire && (op == OP_GUIDE)),
        .waddr (guide_widx[GUIDE_AW-1:0]),
        .wdata ({guide_high, guide_low}),
        .re    (adv),
        .raddr (guide_ridx[GUIDE_AW-1:0]),
        .rdata (guide_q)
    );

    // Threshold copy that serves the check against entry 254.
    gcbs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (THR_DEPTH)
    ) u_top_ram (
        .clk   (clk),
        .we    (in_fire && (op == OP_THR)),
        .waddr (thr_widx[THR_AW-1:0]),
        .wdata (threshold_word),
        .re    (adv),
        .raddr (thr_ridx[THR_AW-1:0]),
        .rdata (top_q)
    );

    // Capture the transaction while the stores are read.
    always_comb
    begin
        a_item_next       = '0;
        a_item_next.op    = op;
        a_item_next.set   = set_in;
        a_item_next.entry = entry_index;
        a_item_next.word  = (op == OP_THR) ? threshold_word : random_word;
    end

    // Order the guide bounds and flag words at or above threshold 254.
    always_comb
    begin
        b_item_next = a_item_reg;
        if (guide_q[7:0] > guide_q[15:8])
        begin
            b_item_next.lo = guide_q[15:8];
            b_item_next.hi = guide_q[7:0];
        end
        else
        begin
            b_item_next.lo = guide_q[7:0];
            b_item_next.hi = guide_q[15:8];
        end
        b_item_next.top = !(a_item_reg.word < top_q);
        b_item_next.act = 1'b0;
    end

    // Valid bits of the two front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    // Payload of the two front stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_item_reg <= a_item_next;
            b_item_reg <= b_item_next;
        end
    end

    assign valid_o = b_valid_reg;
    assign item_o  = b_item_reg;

endmodule

### hdl/gcbs_step.sv
// One bisection step: applies the previous compare and reads its own threshold copy.
module gcbs_step import gcbs_pkg::*; #(
    parameter int TABLE_SETS = TABLE_SETS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              valid_i,
    input  stage_t            item_i,
    input  logic [WORD_W-1:0] q_i,
    output logic              valid_o,
    output stage_t            item_o,
    output logic [WORD_W-1:0] q_o
);

    localparam int THR_DEPTH = TABLE_SETS * OUTCOMES;
    localparam int THR_AW    = $clog2(THR_DEPTH);

    stage_t           cur;
    logic [IDX_W:0]   mid_sum;
    logic [IDX_W-1:0] read_idx;
    logic [31:0]      thr_widx;
    logic [31:0]      thr_ridx;
    logic             valid_reg;
    stage_t           item_reg;

    // Narrow the bounds with the threshold read by the previous step, then pick the next probe.
    always_comb
    begin
        cur = item_i;
        if (item_i.act)
        begin
            if (item_i.word < q_i)
            begin
                cur.hi = item_i.mid;
            end
            else
            begin
                cur.lo = item_i.mid;
            end
        end
        mid_sum = {1'b0, cur.lo} + {1'b0, cur.hi};
        cur.mid = mid_sum[IDX_W:1];
        cur.act = (item_i.op == OP_SAMPLE) && ((cur.hi - cur.lo) > 8'd1);
    end

    // A finished search probes its low bound for the final choice.
    assign read_idx = cur.act ? cur.mid : cur.lo;
    assign thr_widx = thr_index(item_i.set, item_i.entry);
    assign thr_ridx = thr_index(cur.set, read_idx);

    // This step's copy of the thresholds, written as a load transaction passes.
    gcbs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (THR_DEPTH)
    ) u_thr_ram (
        .clk   (clk),
        .we    (valid_i && (item_i.op == OP_THR)),
        .waddr (thr_widx[THR_AW-1:0]),
        .wdata (item_i.word),
        .re    (adv),
        .raddr (thr_ridx[THR_AW-1:0]),
        .rdata (q_o)
    );

    // Stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_i;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= cur;
        end
    end

    assign valid_o = valid_reg;
    assign item_o  = item_reg;

endmodule

### hdl/guided_cdf_bisection_sampler.sv
// Top level of the guided CDF bisection sampler.
//
// Usage: each input transaction on in_valid/in_ready is a sample (op 0), a threshold load
// (op 1) or a guide load (op 2). A sample yields one transaction on out_valid/out_ready
// carrying chosen_index; loads and op 3 yield nothing. Results leave in input order.
// Throughput: one transaction per cycle unless a result waits at the output. The search
// is two front stages (guide and threshold-254 read, bound ordering) followed by nine
// step stages, each reading its own copy of the threshold store, so ten threshold
// copies plus the guide store serve one probe each per cycle. Loads travel down the
// same pipeline and update each copy as they pass, so every sample sees exactly the
// loads accepted before it.
// Reset clears all valid bits; the stores are not cleared and must be loaded before
// sampling. When the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes and in_ready drops; nothing is lost or repeated.
module guided_cdf_bisection_sampler import gcbs_pkg::*; #(
    parameter int GUIDE_BITS = GUIDE_BITS_DEF,
    parameter int TABLE_SETS = TABLE_SETS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        op,
    input  logic [1:0]        table_set,
    input  logic [IDX_W-1:0]  entry_index,
    input  logic [WORD_W-1:0] threshold_word,
    input  logic [IDX_W-1:0]  guide_low,
    input  logic [IDX_W-1:0]  guide_high,
    input  logic [WORD_W-1:0] random_word,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [IDX_W-1:0]  chosen_index
);

    localparam int N_STEPS = SEARCH_STEPS + 1;

    logic              adv;
    logic              chain_valid [N_STEPS+1];
    stage_t            chain_item  [N_STEPS+1];
    logic [WORD_W-1:0] chain_q     [N_STEPS+1];

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [IDX_W-1:0] chosen_index_reg;
    logic [IDX_W-1:0] chosen_index_next;

    // The pipeline moves whenever the output register is free or being emptied.
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // Guide lookup and top check.
    gcbs_front #(
        .GUIDE_BITS (GUIDE_BITS),
        .TABLE_SETS (TABLE_SETS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .in_valid       (in_valid),
        .op             (op),
        .table_set      (table_set),
        .entry_index    (entry_index),
        .threshold_word (threshold_word),
        .guide_low      (guide_low),
        .guide_high     (guide_high),
        .random_word    (random_word),
        .valid_o        (chain_valid[0]),
        .item_o         (chain_item[0])
    );

    // The first step has no pending compare.
    assign chain_q[0] = '0;

    // Chain of bisection steps; the last one reads the low bound for the final choice.
    for (genvar k = 0; k < N_STEPS; k++)
    begin : g_step
        gcbs_step #(
            .TABLE_SETS (TABLE_SETS)
        ) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .valid_i (chain_valid[k]),
            .item_i  (chain_item[k]),
            .q_i     (chain_q[k]),
            .valid_o (chain_valid[k+1]),
            .item_o  (chain_item[k+1]),
            .q_o     (chain_q[k+1])
        );
    end

    // Final choice between the two remaining candidates, or the top index for a word flagged at or above threshold 254.
    always_comb
    begin
        out_valid_next = chain_valid[N_STEPS] && (chain_item[N_STEPS].op == OP_SAMPLE);
        if (chain_item[N_STEPS].top)
        begin
            chosen_index_next = IDX_TOP;
        end
        else if (chain_item[N_STEPS].word < chain_q[N_STEPS])
        begin
            chosen_index_next = chain_item[N_STEPS].lo;
        end
        else
        begin
            chosen_index_next = chain_item[N_STEPS].hi;
        end
    end

    // Output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            chosen_index_reg <= chosen_index_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign chosen_index = chosen_index_reg;

`ifndef SYNTHESIS
    // After eight halvings the candidate range of a sample is one or two indexes.
    a_search_converged: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[N_STEPS] && (chain_item[N_STEPS].op == OP_SAMPLE)
        |-> (chain_item[N_STEPS].hi >= chain_item[N_STEPS].lo)
            && ((chain_item[N_STEPS].hi - chain_item[N_STEPS].lo) <= 8'd1))
        else $error("search range did not converge");

    // A result only appears for a sample leaving the last step.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg)
        |-> $past(chain_valid[N_STEPS] && (chain_item[N_STEPS].op == OP_SAMPLE)))
        else $error("result without a sample in the last step");

    // A stall freezes the last step stage.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[N_STEPS] && !adv
        |=> chain_valid[N_STEPS] && $stable(chain_item[N_STEPS]))
        else $error("last step changed during a stall");
`endif

endmodule
